[hdl/afmp_pkg.sv]
// Shared types and constants of the ASCII framed message parser.
// No dependencies; the design files refer to this package by scoped names and the testbench files import it.
package afmp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ID_W    = 17;
    localparam int unsigned INDEX_W = 4;
    localparam int unsigned VALUE_W = 8;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    // Register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_START     = 2'd0;
    localparam logic [1:0] REG_END       = 2'd1;
    localparam logic [1:0] REG_ID_END    = 2'd2;
    localparam logic [1:0] REG_SEPARATOR = 2'd3;

    localparam logic [BYTE_W-1:0] RST_START_CODE     = 8'd60;
    localparam logic [BYTE_W-1:0] RST_END_CODE       = 8'd62;
    localparam logic [BYTE_W-1:0] RST_ID_END_CODE    = 8'd58;
    localparam logic [BYTE_W-1:0] RST_SEPARATOR_CODE = 8'd44;

    localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;

    typedef struct packed {
        logic [BYTE_W-1:0] start_code;
        logic [BYTE_W-1:0] end_code;
        logic [BYTE_W-1:0] id_end_code;
        logic [BYTE_W-1:0] separator_code;
    } cfg_t;

    // Classified byte handed from the front to the back
    typedef struct packed {
        logic       is_start;
        logic       is_end;
        logic       is_id_end;
        logic       is_sep;
        logic       is_digit;
        logic [3:0] digit;
    } token_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_ID    = 4'b0010,
        PH_FIELD = 4'b0100,
        PH_DROP  = 4'b1000
    } phase_t;

endpackage

[hdl/afmp_if.sv]
// Valid/ready channel interfaces of the ASCII framed message parser.
// Depends on afmp_pkg for the payload widths.
interface afmp_in_if;
    logic                         valid;
    logic                         ready;
    logic [afmp_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface afmp_out_if;
    logic                          valid;
    logic                          ready;
    logic [afmp_pkg::ID_W-1:0]     msg_id;
    logic [afmp_pkg::INDEX_W-1:0]  field_index;
    logic [afmp_pkg::VALUE_W-1:0]  field_value;
    logic                          last;

    modport source (output valid, output msg_id, output field_index, output field_value,
                    output last, input ready);
    modport sink   (input valid, input msg_id, input field_index, input field_value,
                    input last, output ready);
endinterface

[hdl/afmp_regs.sv]
// APB-style configuration registers of the ASCII framed message parser.
// Depends on afmp_pkg.
module afmp_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [afmp_pkg::ADDR_W-1:0]   paddr,
    input  logic [afmp_pkg::DATA_W-1:0]   pwdata,
    output logic [afmp_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output afmp_pkg::cfg_t                cfg
);

    afmp_pkg::cfg_t              cfg_reg;
    logic                        wr_en;
    logic [1:0]                  reg_sel;
    logic [afmp_pkg::BYTE_W-1:0] rd_byte;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_code     <= afmp_pkg::RST_START_CODE;
            cfg_reg.end_code       <= afmp_pkg::RST_END_CODE;
            cfg_reg.id_end_code    <= afmp_pkg::RST_ID_END_CODE;
            cfg_reg.separator_code <= afmp_pkg::RST_SEPARATOR_CODE;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                afmp_pkg::REG_START:     cfg_reg.start_code     <= pwdata[7:0];
                afmp_pkg::REG_END:       cfg_reg.end_code       <= pwdata[7:0];
                afmp_pkg::REG_ID_END:    cfg_reg.id_end_code    <= pwdata[7:0];
                afmp_pkg::REG_SEPARATOR: cfg_reg.separator_code <= pwdata[7:0];
                default:                 cfg_reg.start_code     <= cfg_reg.start_code;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            afmp_pkg::REG_START:     rd_byte = cfg_reg.start_code;
            afmp_pkg::REG_END:       rd_byte = cfg_reg.end_code;
            afmp_pkg::REG_ID_END:    rd_byte = cfg_reg.id_end_code;
            afmp_pkg::REG_SEPARATOR: rd_byte = cfg_reg.separator_code;
            default:                 rd_byte = '0;
        endcase
    end

    assign prdata = {{(afmp_pkg::DATA_W - afmp_pkg::BYTE_W){1'b0}}, rd_byte};
    assign cfg    = cfg_reg;

endmodule

[hdl/afmp_front.sv]
// Front end: accept received bytes, classify them against the codes and
// hold them in a two-entry token queue. Depends on afmp_pkg and afmp_if.
module afmp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  afmp_pkg::cfg_t    cfg,
    afmp_in_if.sink           rx,
    output logic              tok_valid,
    output afmp_pkg::token_t  tok,
    input  logic              tok_pop
);

    afmp_pkg::token_t q_mem [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             push;
    logic             pop;
    afmp_pkg::token_t cls;

    // Classify the incoming byte
    always_comb
    begin
        cls.is_start  = (rx.rx_byte == cfg.start_code);
        cls.is_end    = (rx.rx_byte == cfg.end_code);
        cls.is_id_end = (rx.rx_byte == cfg.id_end_code);
        cls.is_sep    = (rx.rx_byte == cfg.separator_code);
        cls.is_digit  = rx.rx_byte inside {[afmp_pkg::CHAR_ZERO:afmp_pkg::CHAR_NINE]};
        cls.digit     = rx.rx_byte[3:0];
    end

    assign rx.ready  = (count_reg != 2'd2);
    assign push      = rx.valid && rx.ready;
    assign tok_valid = (count_reg != 2'd0);
    assign pop       = tok_pop && tok_valid;
    assign tok       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("token queue count out of range");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_pop && count_reg == 2'd0) |=> (count_reg == $past(count_reg) + {1'b0, $past(push)}))
        else $error("token queue count moved on an empty pop");
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("token queue lost a push");
`endif

endmodule

[hdl/afmp_back.sv]
// Back end: run the message state machine over queued tokens and hold each
// closed field within the field capacity in the output register. Depends on afmp_pkg and afmp_if.
module afmp_back #(
    parameter int unsigned MAX_FIELDS   = 16,
    parameter int unsigned ID_DIGITS    = 5,
    parameter int unsigned FIELD_DIGITS = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tok_valid,
    input  afmp_pkg::token_t  tok,
    output logic              tok_pop,
    afmp_out_if.source        result
);

    localparam int unsigned ICW = $clog2(ID_DIGITS + 1);
    localparam int unsigned FCW = $clog2(FIELD_DIGITS + 1);
    localparam int unsigned CW  = $clog2(MAX_FIELDS + 1);

    afmp_pkg::phase_t              phase_reg, phase_next;
    logic [afmp_pkg::ID_W-1:0]     id_accum_reg, id_accum_next;
    logic [ICW-1:0]                id_chars_reg, id_chars_next;
    logic                          id_stopped_reg, id_stopped_next;
    logic [afmp_pkg::VALUE_W-1:0]  field_accum_reg, field_accum_next;
    logic [FCW-1:0]                field_chars_reg, field_chars_next;
    logic                          field_stopped_reg, field_stopped_next;
    logic [CW-1:0]                 field_count_reg, field_count_next;

    logic                          out_valid_reg, out_valid_next;
    logic [afmp_pkg::ID_W-1:0]     out_id_reg;
    logic [afmp_pkg::INDEX_W-1:0]  out_index_reg;
    logic [afmp_pkg::VALUE_W-1:0]  out_value_reg;
    logic                          out_last_reg;

    logic                          take;
    logic                          emit;
    logic                          close_field;
    logic [CW+3:0]                 count_ext;
    logic [afmp_pkg::ID_W-1:0]     id_times_ten;
    logic [afmp_pkg::VALUE_W-1:0]  field_times_ten;

    assign take     = !out_valid_reg || result.ready;
    assign tok_pop  = tok_valid && take;
    assign count_ext = {4'b0000, field_count_reg};

    // Accumulators keep only the bits that reach the output: x*10 = x*8 + x*2
    assign id_times_ten    = (id_accum_reg << 3) + (id_accum_reg << 1);
    assign field_times_ten = (field_accum_reg << 3) + (field_accum_reg << 1);

    assign close_field = (field_chars_reg >= FCW'(FIELD_DIGITS)) || tok.is_sep || tok.is_end;

    always_comb
    begin
        phase_next         = phase_reg;
        id_accum_next      = id_accum_reg;
        id_chars_next      = id_chars_reg;
        id_stopped_next    = id_stopped_reg;
        field_accum_next   = field_accum_reg;
        field_chars_next   = field_chars_reg;
        field_stopped_next = field_stopped_reg;
        field_count_next   = field_count_reg;
        emit               = 1'b0;

        if (tok_pop)
        begin
            case (phase_reg)
                afmp_pkg::PH_IDLE:
                begin
                    if (tok.is_start)
                    begin
                        phase_next         = afmp_pkg::PH_ID;
                        id_accum_next      = '0;
                        id_chars_next      = '0;
                        id_stopped_next    = 1'b0;
                        field_accum_next   = '0;
                        field_chars_next   = '0;
                        field_stopped_next = 1'b0;
                        field_count_next   = '0;
                    end
                end
                afmp_pkg::PH_ID:
                begin
                    if (tok.is_id_end)
                    begin
                        phase_next         = afmp_pkg::PH_FIELD;
                        field_accum_next   = '0;
                        field_chars_next   = '0;
                        field_stopped_next = 1'b0;
                    end
                    else if (tok.is_end)
                    begin
                        phase_next = afmp_pkg::PH_IDLE;
                    end
                    else if (id_chars_reg < ICW'(ID_DIGITS))
                    begin
                        id_chars_next = id_chars_reg + 1'b1;
                        if (!id_stopped_reg)
                        begin
                            if (tok.is_digit)
                            begin
                                id_accum_next = id_times_ten
                                              + {{(afmp_pkg::ID_W-4){1'b0}}, tok.digit};
                            end
                            else
                            begin
                                id_stopped_next = 1'b1;
                            end
                        end
                    end
                end
                afmp_pkg::PH_FIELD:
                begin
                    if (close_field)
                    begin
                        if (field_count_reg < CW'(MAX_FIELDS))
                        begin
                            emit             = 1'b1;
                            field_count_next = field_count_reg + 1'b1;
                            phase_next       = tok.is_end ? afmp_pkg::PH_IDLE
                                                          : afmp_pkg::PH_FIELD;
                        end
                        else
                        begin
                            phase_next = tok.is_end ? afmp_pkg::PH_IDLE
                                                    : afmp_pkg::PH_DROP;
                        end
                        field_accum_next   = '0;
                        field_chars_next   = '0;
                        field_stopped_next = 1'b0;
                    end
                    else
                    begin
                        field_chars_next = field_chars_reg + 1'b1;
                        if (!field_stopped_reg)
                        begin
                            if (tok.is_digit)
                            begin
                                field_accum_next = field_times_ten
                                                 + {{(afmp_pkg::VALUE_W-4){1'b0}}, tok.digit};
                            end
                            else
                            begin
                                field_stopped_next = 1'b1;
                            end
                        end
                    end
                end
                afmp_pkg::PH_DROP:
                begin
                    if (tok.is_end)
                    begin
                        phase_next = afmp_pkg::PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = afmp_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= afmp_pkg::PH_IDLE;
            id_accum_reg      <= '0;
            id_chars_reg      <= '0;
            id_stopped_reg    <= 1'b0;
            field_accum_reg   <= '0;
            field_chars_reg   <= '0;
            field_stopped_reg <= 1'b0;
            field_count_reg   <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            id_accum_reg      <= id_accum_next;
            id_chars_reg      <= id_chars_next;
            id_stopped_reg    <= id_stopped_next;
            field_accum_reg   <= field_accum_next;
            field_chars_reg   <= field_chars_next;
            field_stopped_reg <= field_stopped_next;
            field_count_reg   <= field_count_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Result payload, loaded only when a closed field is emitted
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_id_reg    <= id_accum_reg;
            out_index_reg <= count_ext[3:0];
            out_value_reg <= field_accum_reg;
            out_last_reg  <= tok.is_end;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.msg_id      = out_id_reg;
    assign result.field_index = out_index_reg;
    assign result.field_value = out_value_reg;
    assign result.last        = out_last_reg;

`ifndef SYNTHESIS
    a_last_ends_msg: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && tok.is_end) |=> (phase_reg == afmp_pkg::PH_IDLE))
        else $error("message not closed after last field");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        field_count_reg <= CW'(MAX_FIELDS))
        else $error("field count beyond capacity");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || result.ready))
        else $error("pending result overwritten");
    a_id_chars_bound: assert property (@(posedge clk) disable iff (!rst_n)
        id_chars_reg <= ICW'(ID_DIGITS))
        else $error("identifier character count beyond limit");
`endif

endmodule

[hdl/ascii_framed_message_parser.sv]
// Top level of the ASCII framed message parser: APB registers, byte front end,
// parsing back end. Depends on afmp_pkg, afmp_if, afmp_regs, afmp_front, afmp_back.
//
// Parses a stream of received serial bytes, one byte per transaction on rx,
// into framed messages of the form <start> ID <id_end> f0 <sep> f1 ... <end>.
// Bytes are dropped until the start code; the decimal ID (first ID_DIGITS
// characters count, conversion stops at the first non-digit) runs to the
// ID-end code; an end code before that discards the message. Each data field
// closes on the separator, on the end code (then last is set), or on a
// character past FIELD_DIGITS, which is consumed and dropped. Every closed
// field produces one transaction on result with the ID, the field index and
// the value modulo 256; once MAX_FIELDS fields are out, the rest of the
// message up to its end code is dropped silently. Throughput is one byte per
// clock cycle while the result sink keeps up: the front end classifies each byte
// against the four codes into a two-entry token queue, and the back end consumes
// one token per cycle into a registered result stage while that stage is free,
// so a stalled result sink only stops the back end while the queue absorbs up
// to two more bytes. An accepted byte is written into the token queue, and a
// popped token that closes a field loads the result register. Write the code
// registers (start 0x0, end 0x4, ID-end 0x8, separator 0xC; low 8 bits of
// pwdata) only while the parser is idle with no transaction in flight.
module ascii_framed_message_parser #(
    parameter int unsigned MAX_FIELDS   = 16,
    parameter int unsigned ID_DIGITS    = 5,
    parameter int unsigned FIELD_DIGITS = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    afmp_in_if.sink                       rx,
    afmp_out_if.source                    result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [afmp_pkg::ADDR_W-1:0]   paddr,
    input  logic [afmp_pkg::DATA_W-1:0]   pwdata,
    output logic [afmp_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    afmp_pkg::cfg_t   cfg;
    logic             tok_valid;
    logic             tok_pop;
    afmp_pkg::token_t tok;

    // Hold the four framing codes
    afmp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Accept and classify bytes, queue them as tokens
    afmp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .rx        (rx),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop)
    );

    // Advance the message state machine and emit closed fields
    afmp_back #(
        .MAX_FIELDS   (MAX_FIELDS),
        .ID_DIGITS    (ID_DIGITS),
        .FIELD_DIGITS (FIELD_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok       (tok),
        .tok_pop   (tok_pop),
        .result    (result)
    );

endmodule

[tb/afmp_check_pkg.sv]
// Field predictor and scoreboard for the ASCII framed message parser testbench.
// Depends on afmp_pkg for widths, code register indexes and the phase encoding.
package afmp_check_pkg;

    import afmp_pkg::*;

    localparam int unsigned MAX_FIELDS   = 16;
    localparam int unsigned ID_DIGITS    = 5;
    localparam int unsigned FIELD_DIGITS = 3;

    typedef struct packed {
        logic [ID_W-1:0]    msg_id;
        logic [INDEX_W-1:0] field_index;
        logic [VALUE_W-1:0] field_value;
        logic               last;
    } field_rec_t;

    class field_tracker;

        cfg_t        codes;
        phase_t      phase;
        logic [31:0] id_accum;
        int unsigned id_chars;
        bit          id_stopped;
        logic [31:0] field_accum;
        int unsigned field_chars;
        bit          field_stopped;
        int unsigned field_count;

        field_rec_t  pending_fields[$];
        int unsigned mismatches;
        int unsigned fields_seen;

        function new();
            codes.start_code     = RST_START_CODE;
            codes.end_code       = RST_END_CODE;
            codes.id_end_code    = RST_ID_END_CODE;
            codes.separator_code = RST_SEPARATOR_CODE;
            phase         = PH_IDLE;
            id_accum      = '0;
            id_chars      = 0;
            id_stopped    = 1'b0;
            field_count   = 0;
            mismatches    = 0;
            fields_seen   = 0;
            clear_field();
        endfunction

        function void clear_field();
            field_accum   = '0;
            field_chars   = 0;
            field_stopped = 1'b0;
        endfunction

        function void set_code(logic [1:0] idx, logic [BYTE_W-1:0] value);
            case (idx)
                REG_START:     codes.start_code     = value;
                REG_END:       codes.end_code       = value;
                REG_ID_END:    codes.id_end_code    = value;
                REG_SEPARATOR: codes.separator_code = value;
                default: ;
            endcase
        endfunction

        // Advance the parser state by one accepted byte; queue the field it closes.
        function void absorb_byte(logic [BYTE_W-1:0] b);
            bit         is_digit;
            bit         closing_end;
            field_rec_t rec;
            is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
            case (phase)
                PH_IDLE:
                begin
                    if (b == codes.start_code)
                    begin
                        phase       = PH_ID;
                        id_accum    = '0;
                        id_chars    = 0;
                        id_stopped  = 1'b0;
                        field_count = 0;
                        clear_field();
                    end
                end
                PH_ID:
                begin
                    // ID-end wins over end when the two codes are equal
                    if (b == codes.id_end_code)
                    begin
                        phase = PH_FIELD;
                        clear_field();
                    end
                    else if (b == codes.end_code)
                        phase = PH_IDLE;
                    else if (id_chars < ID_DIGITS)
                    begin
                        id_chars++;
                        if (!id_stopped)
                        begin
                            if (is_digit)
                                id_accum = id_accum * 10 + 32'(b - CHAR_ZERO);
                            else
                                id_stopped = 1'b1;
                        end
                    end
                end
                PH_FIELD:
                begin
                    if (field_chars >= FIELD_DIGITS || b == codes.separator_code ||
                        b == codes.end_code)
                    begin
                        closing_end = (b == codes.end_code);
                        if (field_count < MAX_FIELDS)
                        begin
                            rec.msg_id      = id_accum[ID_W-1:0];
                            rec.field_index = field_count[INDEX_W-1:0];
                            rec.field_value = field_accum[VALUE_W-1:0];
                            rec.last        = closing_end;
                            pending_fields.push_back(rec);
                            field_count++;
                            phase = closing_end ? PH_IDLE : PH_FIELD;
                        end
                        else
                            phase = closing_end ? PH_IDLE : PH_DROP;
                        clear_field();
                    end
                    else
                    begin
                        field_chars++;
                        if (!field_stopped)
                        begin
                            if (is_digit)
                                field_accum = field_accum * 10 + 32'(b - CHAR_ZERO);
                            else
                                field_stopped = 1'b1;
                        end
                    end
                end
                default:
                begin
                    if (b == codes.end_code)
                        phase = PH_IDLE;
                end
            endcase
        endfunction

        task flag(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        task compare_field(field_rec_t got);
            field_rec_t want;
            if (pending_fields.size() == 0)
            begin
                flag($sformatf("unexpected field id %0d index %0d value %0d last %0b",
                               got.msg_id, got.field_index, got.field_value, got.last));
                return;
            end
            want = pending_fields.pop_front();
            fields_seen++;
            if (got.msg_id != want.msg_id || got.field_index != want.field_index ||
                got.field_value != want.field_value || got.last != want.last)
                flag($sformatf("field got id %0d idx %0d val %0d last %0b, want %0d %0d %0d %0b",
                               got.msg_id, got.field_index, got.field_value, got.last,
                               want.msg_id, want.field_index, want.field_value, want.last));
        endtask

    endclass

endpackage

[tb/tb_ascii_framed_message_parser.sv]
// Top-level testbench of the ASCII framed message parser: clock, reset, byte
// source, result sink, APB code programming. Depends on afmp_pkg, afmp_if,
// afmp_check_pkg and the ascii_framed_message_parser RTL.
module tb_ascii_framed_message_parser;

    import afmp_pkg::*;
    import afmp_check_pkg::*;

    localparam int unsigned HALF_PERIOD    = 10;
    localparam int unsigned CLK_PERIOD     = 2 * HALF_PERIOD;
    localparam int unsigned SETTLE_CYCLES  = 10;    // covers the token queue and the result register
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned END_WAIT_LIMIT = 4000;
    localparam int unsigned TIMEOUT_CYCLES = 400000;

    // Short directed prologue under the reset codes
    localparam logic [BYTE_W-1:0] DIRECTED_BYTES [28] = '{
        8'h00, 8'hFF,                                      // noise while hunting
        RST_START_CODE, "1", "2", RST_END_CODE,            // end before ID-end
        RST_START_CODE, "9", "9", "9", "9", "9", "7",      // long ID, max value
        RST_ID_END_CODE,
        "9", "9", "9", "9",                                // fourth char closes 999
        RST_SEPARATOR_CODE,                                // empty field
        "1", "a", "2", RST_END_CODE,                       // conversion stops at 'a'
        RST_START_CODE, "a", RST_START_CODE,               // start byte inside ID
        RST_ID_END_CODE, RST_END_CODE                      // empty last field
    };

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    afmp_in_if  rx_if ();
    afmp_out_if res_if ();

    field_tracker tracker = new();

    // Idle control shared between the stimulus process and the result sink
    bit          src_calm;
    bit          snk_calm;
    int unsigned hold_req;
    int unsigned hold_left;
    int unsigned stall_left;
    int unsigned bytes_counted;
    int unsigned frames_sent;

    ascii_framed_message_parser #(
        .MAX_FIELDS   (MAX_FIELDS),
        .ID_DIGITS    (ID_DIGITS),
        .FIELD_DIGITS (FIELD_DIGITS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_if),
        .result  (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        clk = 1'b0;
        #HALF_PERIOD;
        clk = 1'b1;
        #HALF_PERIOD;
    end

    // Idle length: mostly none, often short, now and then long
    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Mostly decimal digits, the rest any byte value at all
    function automatic logic [BYTE_W-1:0] pick_char();
        if ($urandom_range(0, 99) < 75)
            return CHAR_ZERO + BYTE_W'($urandom_range(0, 9));
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    // Offer one byte after a random gap and hold it until the parser takes it.
    // Valid stays high after the transaction, so back-to-back bytes never
    // drop and re-raise it within one time step.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int unsigned gap;
        gap = pick_gap(src_calm);
        if (gap != 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (rx_if.ready !== 1'b1);
        tracker.absorb_byte(b);
    endtask

    // One APB write followed by a readback of the same register, then psel
    // is returned low so the next transfer starts cleanly.
    task automatic write_reg(input logic [1:0] idx, input logic [BYTE_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(DATA_W-BYTE_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        tracker.set_code(idx, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        if (prdata !== {{(DATA_W-BYTE_W){1'b0}}, value})
            tracker.flag($sformatf("register %0d reads %h, written %h", idx, prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_codes(input cfg_t c);
        write_reg(REG_START, c.start_code);
        write_reg(REG_END, c.end_code);
        write_reg(REG_ID_END, c.id_end_code);
        write_reg(REG_SEPARATOR, c.separator_code);
    endtask

    // Drop valid, wait for every expected field, then let trailing bytes that
    // close nothing drain out of the token queue.
    task automatic settle();
        rx_if.valid <= 1'b0;
        while (tracker.pending_fields.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Build one frame under the current codes: mostly well-formed messages
    // with random content, some noise and some broken messages.
    task automatic send_frame();
        logic [BYTE_W-1:0] frame[$];
        int unsigned       kind;
        int unsigned       nfields;
        int unsigned       cut;
        int unsigned       f;
        kind     = $urandom_range(0, 9);
        src_calm = ($urandom_range(0, 4) == 0);
        snk_calm = ($urandom_range(0, 4) == 0);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 5)) frame.push_back(BYTE_W'($urandom_range(0, 255)));
        end
        else
        begin
            frame.push_back(tracker.codes.start_code);
            repeat ($urandom_range(0, 7)) frame.push_back(pick_char());
            if (kind == 1)
                frame.push_back(tracker.codes.end_code);
            else
            begin
                frame.push_back(tracker.codes.id_end_code);
                // A few messages run past the field capacity
                nfields = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 19)
                                                      : $urandom_range(1, 5);
                for (f = 0; f < nfields; f++)
                begin
                    repeat ($urandom_range(0, 4)) frame.push_back(pick_char());
                    frame.push_back((f == nfields - 1) ? tracker.codes.end_code
                                                       : tracker.codes.separator_code);
                end
                // Truncate now and then; the next frame then lands mid-message
                if (kind == 2)
                begin
                    cut = $urandom_range(1, frame.size() - 1);
                    while (frame.size() > cut)
                        void'(frame.pop_back());
                end
            end
        end
        foreach (frame[i])
            send_byte(frame[i]);
        if (kind != 0)
            bytes_counted += frame.size();
        frames_sent++;
    endtask

    task automatic run_frames(input int unsigned target);
        int unsigned start_count;
        start_count = bytes_counted;
        while (bytes_counted - start_count < target)
            send_frame();
    endtask

    // Result sink: check each transaction, then choose ready for the next
    // cycle. A pressure request holds ready low for a long counted stretch.
    initial
    begin
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1)
                tracker.compare_field('{res_if.msg_id, res_if.field_index,
                                        res_if.field_value, res_if.last});
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                res_if.ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left--;
                res_if.ready <= 1'b0;
            end
            else
            begin
                stall_left = pick_gap(snk_calm);
                if (stall_left != 0)
                begin
                    stall_left--;
                    res_if.ready <= 1'b0;
                end
                else
                    res_if.ready <= 1'b1;
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        cfg_t        codes;
        logic [7:0]  shared_code;
        int unsigned f;
        int unsigned n;
        int unsigned waited;
        rst_n         <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        src_calm      = 1'b0;
        snk_calm      = 1'b0;
        hold_req      = 0;
        hold_left     = 0;
        stall_left    = 0;
        bytes_counted = 0;
        frames_sent   = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed prologue, then random frames, all under the reset codes
        foreach (DIRECTED_BYTES[i])
            send_byte(DIRECTED_BYTES[i]);
        bytes_counted += $size(DIRECTED_BYTES);
        run_frames(120);
        settle();

        // Extreme code values
        codes = '{start_code: 8'h00, end_code: 8'hFF, id_end_code: 8'h80,
                  separator_code: 8'h7F};
        program_codes(codes);
        run_frames(90);
        settle();

        // End, ID-end and separator all equal: ID-end wins in the ID phase,
        // the end code closes the field as last in the field phase
        shared_code = 8'($urandom_range(0, 255));
        codes = '{start_code: 8'($urandom_range(0, 255)), end_code: shared_code,
                  id_end_code: shared_code, separator_code: shared_code};
        program_codes(codes);
        run_frames(80);
        settle();

        // Random codes with a decimal digit as the ID-end code
        codes = '{start_code: 8'($urandom_range(0, 255)), end_code: 8'($urandom_range(0, 255)),
                  id_end_code: CHAR_ZERO + 8'($urandom_range(0, 9)),
                  separator_code: 8'($urandom_range(0, 255))};
        program_codes(codes);
        run_frames(90);
        settle();

        // Back to the reset codes, written explicitly
        codes = '{start_code: RST_START_CODE, end_code: RST_END_CODE,
                  id_end_code: RST_ID_END_CODE, separator_code: RST_SEPARATOR_CODE};
        program_codes(codes);

        // Pressure: hold off the sink while a message of many short fields
        // streams in back to back, so the parser fills and stalls its input
        hold_req = HOLD_CYCLES;
        src_calm = 1'b1;
        send_byte(tracker.codes.start_code);
        repeat (5) send_byte(pick_char());
        send_byte(tracker.codes.id_end_code);
        bytes_counted += 7;
        for (f = 0; f < MAX_FIELDS + 4; f++)
        begin
            n = $urandom_range(1, 2);
            repeat (n) send_byte(pick_char());
            send_byte((f == MAX_FIELDS + 3) ? tracker.codes.end_code
                                            : tracker.codes.separator_code);
            bytes_counted += n + 1;
        end
        run_frames(100);

        // Drain with a bound, then look for fields that never arrived
        rx_if.valid <= 1'b0;
        for (waited = 0; tracker.pending_fields.size() != 0 && waited < END_WAIT_LIMIT;
             waited++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.pending_fields.size() != 0)
            tracker.flag($sformatf("%0d expected fields never arrived",
                                   tracker.pending_fields.size()));

        $display("Sent %0d message bytes in %0d frames under five code settings,",
                 bytes_counted, frames_sent);
        $display("including equal and digit codes; %0d fields checked, sink hold %0d cycles.",
                 tracker.fields_seen, HOLD_CYCLES);
        if (tracker.mismatches == 0)
            $display("ascii_framed_message_parser verification clean");
        else
            $display("ascii_framed_message_parser verification failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("ascii_framed_message_parser verification failed");
        $finish;
    end

endmodule
